@@ sv/assert_macros.svh @@
// Assertion helpers shared by the blitter modules.
// Each macro expands to one labelled concurrent assertion on a rising clock edge,
// gated off while the synchronous active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ sv/cckb_pkg.sv @@
// Shared types, constants and helpers for the colour-keyed clipped blitter.
// No dependencies; imported by the interfaces and every module of the block.
`default_nettype none

package cckb_pkg;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // register indexes, byte address = 4 * index
    localparam logic [2:0] REG_SRC_X      = 3'd0;
    localparam logic [2:0] REG_SRC_Y      = 3'd1;
    localparam logic [2:0] REG_SRC_STRIDE = 3'd2;
    localparam logic [2:0] REG_RECT_W     = 3'd3;
    localparam logic [2:0] REG_RECT_H     = 3'd4;
    localparam logic [2:0] REG_DST_X      = 3'd5;
    localparam logic [2:0] REG_DST_Y      = 3'd6;
    localparam logic [2:0] REG_KEY_COLOR  = 3'd7;

    localparam logic [7:0]  KEY_RESET  = 8'h0D;
    localparam logic [10:0] SIZE_MAX   = 11'd1024;

    typedef logic [7:0]  t_pix;
    typedef logic [9:0]  t_cnt;
    typedef logic [15:0] t_addr;
    typedef logic [21:0] t_sidx;

    typedef struct packed {
        logic [9:0]         src_x;
        logic [9:0]         src_y;
        logic [10:0]        src_stride;
        logic [10:0]        rect_w;
        logic [10:0]        rect_h;
        logic signed [10:0] dst_x;
        logic signed [10:0] dst_y;
        t_pix               key_color;
    } t_cfg;

    // item held in the input register
    typedef struct packed {
        t_pix pixel;
        t_cnt col;
        t_cnt row;
        logic last;
    } t_s1;

    typedef struct packed {
        logic  write_enable;
        t_addr dest_addr;
        t_pix  color;
        t_sidx source_index;
        logic  last;
    } t_res;

    // zero acts as one, anything above the maximum as the maximum
    function automatic logic [10:0] clamp_size(input logic [10:0] v);
        logic [10:0] r;
        r = v;
        if (v == 11'd0) begin
            r = 11'd1;
        end else if (v > SIZE_MAX) begin
            r = SIZE_MAX;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/cckb_pix_if.sv @@
// Source pixel stream channel: valid/ready handshake plus one colour index.
// Depends on cckb_pkg.
`default_nettype none

interface cckb_pix_if;
    import cckb_pkg::*;

    logic valid;
    logic ready;
    t_pix pixel;

    modport source(output valid, output pixel, input ready);
    modport sink(input valid, input pixel, output ready);
endinterface

`default_nettype wire

@@ sv/cckb_res_if.sv @@
// Result stream channel: valid/ready handshake plus the framebuffer write fields.
// Depends on cckb_pkg.
`default_nettype none

interface cckb_res_if;
    import cckb_pkg::*;

    logic  valid;
    logic  ready;
    logic  write_enable;
    t_addr dest_addr;
    t_pix  color;
    t_sidx source_index;
    logic  last;

    modport source(output valid, output write_enable, output dest_addr, output color,
                   output source_index, output last, input ready);
    modport sink(input valid, input write_enable, input dest_addr, input color,
                 input source_index, input last, output ready);
endinterface

`default_nettype wire

@@ sv/clipped_color_key_blit_top.sv @@
// Colour-keyed sprite blitter with screen clipping; top level of the block.
// Depends on cckb_pkg, cckb_pix_if, cckb_res_if, cckb_cfg, cckb_ctr and cckb_calc.
`default_nettype none

// The block takes one source pixel per clock while the result side is not stalled, and
// returns one result per pixel: the pixel is captured with its column and row in an
// input register, then the clipping test, the key compare and the two address
// products (row times screen width, source row times stride) settle into the result
// register. Pixels come in row-major order over a rect_w by rect_h rectangle (zero acts
// as one, above 1024 as 1024); the pixel flagged last closes the rectangle and the
// counters restart. A stalled result holds its stage; pixels are then taken only while
// the input register is empty. Program the registers over the APB port only between
// rectangles with nothing in flight; register i sits at byte address 4*i.
module clipped_color_key_blit_top #(
    parameter int SCREEN_W = 320,
    parameter int SCREEN_H = 200
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [cckb_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [cckb_pkg::PDATA_W-1:0]  pwdata,
    output logic      [cckb_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready,
    cckb_pix_if.sink                           i_pix,
    cckb_res_if.source                         o_res
);
    import cckb_pkg::*;

    t_cfg cfg;
    t_s1  s1;
    logic s1_valid;
    logic take;

    cckb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    cckb_ctr u_ctr (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_pix      (i_pix),
        .i_take     (take),
        .o_s1_valid (s1_valid),
        .o_s1       (s1)
    );

    cckb_calc #(
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H)
    ) u_calc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_s1_valid (s1_valid),
        .i_s1       (s1),
        .o_take     (take),
        .o_res      (o_res)
    );

endmodule

`default_nettype wire

@@ sv/cckb_cfg.sv @@
// APB-style configuration register file for the blitter.
// Depends on cckb_pkg; presents all registers as one t_cfg struct.
`default_nettype none

module cckb_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [cckb_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [cckb_pkg::PDATA_W-1:0]  pwdata,
    output logic      [cckb_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready,
    output cckb_pkg::t_cfg                     o_cfg
);
    import cckb_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_x      <= '0;
            r_cfg.src_y      <= '0;
            r_cfg.src_stride <= 11'd1;
            r_cfg.rect_w     <= 11'd1;
            r_cfg.rect_h     <= 11'd1;
            r_cfg.dst_x      <= '0;
            r_cfg.dst_y      <= '0;
            r_cfg.key_color  <= KEY_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_SRC_X:      r_cfg.src_x      <= pwdata[9:0];
                REG_SRC_Y:      r_cfg.src_y      <= pwdata[9:0];
                REG_SRC_STRIDE: r_cfg.src_stride <= pwdata[10:0];
                REG_RECT_W:     r_cfg.rect_w     <= pwdata[10:0];
                REG_RECT_H:     r_cfg.rect_h     <= pwdata[10:0];
                REG_DST_X:      r_cfg.dst_x      <= pwdata[10:0];
                REG_DST_Y:      r_cfg.dst_y      <= pwdata[10:0];
                REG_KEY_COLOR:  r_cfg.key_color  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SRC_X:      prdata = PDATA_W'(r_cfg.src_x);
            REG_SRC_Y:      prdata = PDATA_W'(r_cfg.src_y);
            REG_SRC_STRIDE: prdata = PDATA_W'(r_cfg.src_stride);
            REG_RECT_W:     prdata = PDATA_W'(r_cfg.rect_w);
            REG_RECT_H:     prdata = PDATA_W'(unsigned'(r_cfg.rect_h));
            REG_DST_X:      prdata = PDATA_W'(unsigned'(r_cfg.dst_x));
            REG_DST_Y:      prdata = PDATA_W'(unsigned'(r_cfg.dst_y));
            REG_KEY_COLOR:  prdata = PDATA_W'(r_cfg.key_color);
            default:        prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ sv/cckb_ctr.sv @@
// Column/row counters and input register of the blitter pipeline.
// Depends on cckb_pkg, cckb_pix_if and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module cckb_ctr (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire cckb_pkg::t_cfg  i_cfg,
    cckb_pix_if.sink             i_pix,
    input  wire logic            i_take,
    output logic                 o_s1_valid,
    output cckb_pkg::t_s1        o_s1
);
    import cckb_pkg::*;

    t_cnt        r_col;
    t_cnt        r_row;
    t_cnt        n_col;
    t_cnt        n_row;
    logic        r_s1_valid;
    t_s1         r_s1;
    logic [10:0] w_eff;
    logic [10:0] h_eff;
    logic        row_end;
    logic        last_now;
    logic        in_fire;

    assign w_eff    = clamp_size(i_cfg.rect_w);
    assign h_eff    = clamp_size(i_cfg.rect_h);
    assign row_end  = (11'({1'b0, r_col}) + 11'd1) >= w_eff;
    assign last_now = row_end && ((11'({1'b0, r_row}) + 11'd1) >= h_eff);

    // the stage frees up when empty or when its item moves on
    assign i_pix.ready = !r_s1_valid || i_take;
    assign in_fire     = i_pix.valid && i_pix.ready;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (in_fire) begin
            if (last_now) begin
                n_col = '0;
                n_row = '0;
            end else if (row_end) begin
                n_col = '0;
                n_row = r_row + 10'd1;
            end else begin
                n_col = r_col + 10'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (i_pix.ready) begin
                r_s1_valid <= i_pix.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1.pixel <= i_pix.pixel;
            r_s1.col   <= r_col;
            r_s1.row   <= r_row;
            r_s1.last  <= last_now;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;

    `ASSERT_NEXT(a_last_restarts, i_clk, i_rst_n, in_fire && last_now,
                 r_col == '0 && r_row == '0)
    `ASSERT_NEXT(a_row_advance, i_clk, i_rst_n, in_fire && row_end && !last_now,
                 r_col == '0 && r_row == 10'($past(r_row) + 10'd1))
    `ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n, r_s1_valid && !i_take,
                 r_s1_valid && $stable(r_s1))

endmodule

`default_nettype wire

@@ sv/cckb_calc.sv @@
// Per-pixel clipping, key test and address arithmetic, ending in the result register.
// Depends on cckb_pkg, cckb_res_if and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module cckb_calc #(
    parameter int SCREEN_W = 320,
    parameter int SCREEN_H = 200
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire cckb_pkg::t_cfg  i_cfg,
    input  wire logic            i_s1_valid,
    input  wire cckb_pkg::t_s1   i_s1,
    output logic                 o_take,
    cckb_res_if.source           o_res
);
    import cckb_pkg::*;

    localparam logic [11:0] SCR_W   = 12'(SCREEN_W);
    localparam logic [11:0] SCR_H   = 12'(SCREEN_H);
    localparam logic [15:0] SCR_W16 = 16'(SCREEN_W);

    logic        r_out_valid;
    t_res        r_out;
    t_res        n_out;
    logic [11:0] fx;
    logic [11:0] fy;
    logic        on_screen;
    logic [10:0] ysum;
    t_addr       addr_full;

    assign o_take = !r_out_valid || o_res.ready;

    always_comb begin
        // signed 12-bit screen position; bit 11 set means left of or above the screen
        fx = {i_cfg.dst_x[10], i_cfg.dst_x} + {2'b00, i_s1.col};
        fy = {i_cfg.dst_y[10], i_cfg.dst_y} + {2'b00, i_s1.row};
        on_screen = !fx[11] && ({1'b0, fx[10:0]} < SCR_W)
                 && !fy[11] && ({1'b0, fy[10:0]} < SCR_H);
        addr_full = 16'(fy[10:0]) * SCR_W16 + 16'(fx[10:0]);
        ysum      = 11'({1'b0, i_cfg.src_y}) + 11'({1'b0, i_s1.row});

        n_out.write_enable = on_screen && (i_s1.pixel != i_cfg.key_color);
        n_out.dest_addr    = n_out.write_enable ? addr_full : '0;
        n_out.color        = i_s1.pixel;
        n_out.source_index = 22'(ysum) * 22'(i_cfg.src_stride)
                           + 22'(i_cfg.src_x) + 22'(i_s1.col);
        n_out.last         = i_s1.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_out_valid <= i_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_s1_valid) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.write_enable = r_out.write_enable;
    assign o_res.dest_addr    = r_out.dest_addr;
    assign o_res.color        = r_out.color;
    assign o_res.source_index = r_out.source_index;
    assign o_res.last         = r_out.last;

    `ASSERT_IMPL(a_masked_addr_zero, i_clk, i_rst_n, r_out_valid && !r_out.write_enable,
                 r_out.dest_addr == '0)
    `ASSERT_NEXT(a_item_lands, i_clk, i_rst_n, i_s1_valid && o_take, r_out_valid)
    `ASSERT_NEXT(a_result_hold, i_clk, i_rst_n, r_out_valid && !o_res.ready,
                 r_out_valid && $stable(r_out))

endmodule

`default_nettype wire
